// ===== rtl/core/cvd_pkg.sv =====
// Package for the class-prefixed value decoder: widths, defaults,
// configuration register indexes and the result tag struct.
// No dependencies.
`default_nettype none

package cvd_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_FLAG_BITS_DEF = 3;
  localparam int VALUE_BITS_DEF    = 32;

  // Fixed field widths
  localparam int FLAG_CFG_W  = 2;
  localparam int LEN_W       = 6;
  localparam int NUM_CLASSES = 8;
  localparam int CLASS_W     = 3;
  localparam int TABLE_W     = NUM_CLASSES * LEN_W;
  localparam int COUNT_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = TABLE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_FLAG_BITS = 3'd0,
    CFG_PIXEL_FLAG_BITS = 3'd1,
    CFG_FRAME_LEN_TABLE = 3'd2,
    CFG_PIXEL_LEN_TABLE = 3'd3,
    CFG_VALUE_COUNT     = 3'd4
  } cfg_index_t;

  // Side-band of one result handed from the decoder to the output buffer
  typedef struct packed {
    logic push;
    logic is_pixel;
    logic last;
  } res_tag_t;

endpackage

`default_nettype wire

// ===== rtl/core/class_prefix_value_decoder_top.sv =====
// Top level of the class-prefixed value decoder.
// Instantiates cvd_decode and cvd_out_buf; depends on cvd_pkg.
//
// Usage:
//  - Bit channel: code_bit with bit_valid/bit_stall. One coded bit per
//    transfer; a transfer happens when bit_valid is high and bit_stall low.
//  - Result channel: value, is_pixel, last with res_valid/res_stall.
//    Values alternate frame number, pixel value, frame number, ...
//  - Config port: cfg_we/cfg_index/cfg_data, written only while idle.
//    Index 0/1 flag widths, 2/3 length tables (six bits per class),
//    4 value count. Unused indexes are ignored.
//  - Throughput: one bit per cycle while bit_stall is low.
//  - Latency: the result of a value enters the buffer the cycle after the
//    transfer of its final bit (last flag bit for a zero-length class).
//  - Once value_count values are decoded, further bits are taken and dropped.
//  - Stall: results queue in a two-entry buffer; bit_stall rises only when
//    both entries hold results, straight from the buffer count register.
//  - Reset (rst, synchronous): config back to widths 1, tables 0, count 0;
//    decode state and buffer cleared; bit_stall low after reset.
`default_nettype none

module class_prefix_value_decoder_top #(
  parameter int MAX_FLAG_BITS = cvd_pkg::MAX_FLAG_BITS_DEF,
  parameter int VALUE_BITS    = cvd_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [cvd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cvd_pkg::CFG_DATA_W-1:0] cfg_data,
  // coded bit stream
  input  logic                           bit_valid,
  output logic                           bit_stall,
  input  logic                           code_bit,
  // decoded values
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [VALUE_BITS-1:0]          value,
  output logic                           is_pixel,
  output logic                           last
);
  import cvd_pkg::*;

  res_tag_t              res_tag;
  logic [VALUE_BITS-1:0] res_value;
  logic                  full;
  logic                  accept;

  // stall only on a full buffer, so any transfer has room for its result
  assign bit_stall = full;
  assign accept    = bit_valid && !bit_stall;

  cvd_decode #(
    .MAX_FLAG_BITS (MAX_FLAG_BITS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .code_bit  (code_bit),
    .res_tag   (res_tag),
    .res_value (res_value)
  );

  cvd_out_buf #(
    .VALUE_BITS (VALUE_BITS)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_tag   (res_tag),
    .res_value (res_value),
    .full      (full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .value     (value),
    .is_pixel  (is_pixel),
    .last      (last)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cvd_decode.sv =====
// Bit-serial decode core: configuration registers, flag/payload state and
// the one-bit-per-transfer update. Depends on cvd_pkg.
`default_nettype none

module cvd_decode #(
  parameter int MAX_FLAG_BITS = cvd_pkg::MAX_FLAG_BITS_DEF,
  parameter int VALUE_BITS    = cvd_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cvd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cvd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                         accept,
  input  logic                         code_bit,
  output cvd_pkg::res_tag_t            res_tag,
  output logic [VALUE_BITS-1:0]        res_value
);
  import cvd_pkg::*;

  // configuration
  logic [FLAG_CFG_W-1:0] frame_flag_bits;
  logic [FLAG_CFG_W-1:0] pixel_flag_bits;
  logic [TABLE_W-1:0]    frame_length_table;
  logic [TABLE_W-1:0]    pixel_length_table;
  logic [COUNT_W-1:0]    value_count;

  // decode state
  logic                     in_payload, in_payload_next;
  logic                     pixel_turn, pixel_turn_next;
  logic [MAX_FLAG_BITS-1:0] flag_accum, flag_accum_next;
  logic [LEN_W-1:0]         bit_counter, bit_counter_next;
  logic [LEN_W-1:0]         payload_length, payload_length_next;
  logic [VALUE_BITS-1:0]    value_accum, value_accum_next;
  logic [COUNT_W-1:0]       values_done, values_done_next;

  logic                     done;
  logic [FLAG_CFG_W-1:0]    flag_sel, flag_width;
  logic [MAX_FLAG_BITS-1:0] fa_shift;
  logic [LEN_W-1:0]         cnt_inc;
  logic [CLASS_W-1:0]       cls;
  logic [NUM_CLASSES-1:0][LEN_W-1:0] len_view;
  logic [LEN_W-1:0]         raw_len, class_len;
  logic [VALUE_BITS-1:0]    va_shift;
  logic                     is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_flag_bits    <= FLAG_CFG_W'(1);
      pixel_flag_bits    <= FLAG_CFG_W'(1);
      frame_length_table <= '0;
      pixel_length_table <= '0;
      value_count        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_FLAG_BITS: frame_flag_bits    <= cfg_data[FLAG_CFG_W-1:0];
        CFG_PIXEL_FLAG_BITS: pixel_flag_bits    <= cfg_data[FLAG_CFG_W-1:0];
        CFG_FRAME_LEN_TABLE: frame_length_table <= cfg_data[TABLE_W-1:0];
        CFG_PIXEL_LEN_TABLE: pixel_length_table <= cfg_data[TABLE_W-1:0];
        CFG_VALUE_COUNT:     value_count        <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    done     = (values_done >= value_count);
    flag_sel = pixel_turn ? pixel_flag_bits : frame_flag_bits;
    if (flag_sel == '0) begin
      flag_width = FLAG_CFG_W'(1);
    end else if (32'(flag_sel) > MAX_FLAG_BITS) begin
      flag_width = FLAG_CFG_W'(MAX_FLAG_BITS);
    end else begin
      flag_width = flag_sel;
    end
    fa_shift  = MAX_FLAG_BITS'({flag_accum, code_bit});
    cnt_inc   = bit_counter + LEN_W'(1);
    cls       = CLASS_W'(fa_shift);
    len_view  = pixel_turn ? pixel_length_table : frame_length_table;
    raw_len   = len_view[cls];
    class_len = (32'(raw_len) > VALUE_BITS) ? LEN_W'(VALUE_BITS) : raw_len;
    va_shift  = VALUE_BITS'({value_accum, code_bit});
    is_last   = ((values_done + COUNT_W'(1)) == value_count);
  end

  always_comb begin
    in_payload_next     = in_payload;
    pixel_turn_next     = pixel_turn;
    flag_accum_next     = flag_accum;
    bit_counter_next    = bit_counter;
    payload_length_next = payload_length;
    value_accum_next    = value_accum;
    values_done_next    = values_done;
    res_tag             = '0;
    res_value           = '0;

    if (accept && !done) begin
      if (!in_payload) begin
        flag_accum_next  = fa_shift;
        bit_counter_next = cnt_inc;
        if (cnt_inc >= LEN_W'(flag_width)) begin
          payload_length_next = class_len;
          bit_counter_next    = '0;
          value_accum_next    = '0;
          if (class_len == '0) begin
            // zero-length class: value 0 leaves with the last flag bit
            res_tag.push = 1'b1;
          end else begin
            in_payload_next = 1'b1;
          end
        end
      end else begin
        value_accum_next = va_shift;
        bit_counter_next = cnt_inc;
        if (cnt_inc >= payload_length) begin
          res_tag.push = 1'b1;
          res_value    = va_shift;
        end
      end

      if (res_tag.push) begin
        res_tag.is_pixel    = pixel_turn;
        res_tag.last        = is_last;
        values_done_next    = values_done + COUNT_W'(1);
        pixel_turn_next     = ~pixel_turn;
        in_payload_next     = 1'b0;
        flag_accum_next     = '0;
        bit_counter_next    = '0;
        payload_length_next = '0;
        value_accum_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload     <= 1'b0;
      pixel_turn     <= 1'b0;
      flag_accum     <= '0;
      bit_counter    <= '0;
      payload_length <= '0;
      value_accum    <= '0;
      values_done    <= '0;
    end else begin
      in_payload     <= in_payload_next;
      pixel_turn     <= pixel_turn_next;
      flag_accum     <= flag_accum_next;
      bit_counter    <= bit_counter_next;
      payload_length <= payload_length_next;
      value_accum    <= value_accum_next;
      values_done    <= values_done_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cvd_out_buf.sv =====
// Two-entry result buffer between the decode core and the result channel.
// Depends on cvd_pkg.
`default_nettype none

module cvd_out_buf #(
  parameter int VALUE_BITS = cvd_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cvd_pkg::res_tag_t     res_tag,
  input  logic [VALUE_BITS-1:0] res_value,
  output logic                  full,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [VALUE_BITS-1:0] value,
  output logic                  is_pixel,
  output logic                  last
);
  import cvd_pkg::*;

  localparam int ENTRY_W = VALUE_BITS + 2;

  logic [1:0][ENTRY_W-1:0] entry;
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = res_valid && !res_stall;
  assign res_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign {value, is_pixel, last} = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (res_tag.push) begin
      entry[wr_ptr] <= {res_value, res_tag.is_pixel, res_tag.last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_tag.push) wr_ptr <= ~wr_ptr;
      if (pop)          rd_ptr <= ~rd_ptr;
      count <= count + 2'(res_tag.push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cvd_checker.sv =====
// Port-level checker for the class-prefixed value decoder, bound to the top.
// Depends on class_prefix_value_decoder_top and cvd_pkg.
`default_nettype none

module cvd_checker #(
  parameter int VALUE_BITS = cvd_pkg::VALUE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  bit_valid,
  input logic                  bit_stall,
  input logic                  res_valid,
  input logic                  res_stall,
  input logic [VALUE_BITS-1:0] value,
  input logic                  is_pixel,
  input logic                  last
);

  // held result keeps its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(value) && $stable(is_pixel)
      && $stable(last))
    else $error("result changed while stalled");

  // bit side stalls only when results are waiting
  a_stall_needs_res: assert property (@(posedge clk) disable iff (rst)
    bit_stall |-> res_valid)
    else $error("bit_stall without pending result");

  // a new result only follows a bit transfer
  a_res_from_bit: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(bit_valid && !bit_stall))
    else $error("result without a bit transfer");

  // reset empties the buffer and releases the bit side
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !res_valid && !bit_stall)
    else $error("not clear after reset");

endmodule

bind class_prefix_value_decoder_top cvd_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_cvd_checker (
  .clk       (clk),
  .rst       (rst),
  .bit_valid (bit_valid),
  .bit_stall (bit_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .value     (value),
  .is_pixel  (is_pixel),
  .last      (last)
);

`default_nettype wire

// ===== tb/cvd_decode_checker.sv =====
// Checker for the class-prefixed value decoder: watches the config port and both
// channels, predicts each decoded value and compares it on its result transfer.
// Depends on cvd_pkg.
module cvd_decode_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cvd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cvd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           bit_valid,
  input  logic                           bit_stall,
  input  logic                           code_bit,
  input  logic                           res_valid,
  input  logic                           res_stall,
  input  logic [31:0]                    value,
  input  logic                           is_pixel,
  input  logic                           last,
  output int                             errors,
  output int                             pending,
  output logic [31:0]                    seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import cvd_pkg::*;

  localparam int VALUE_W = 32;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               is_pixel;
    logic               last;
  } decoded_t;

  decoded_t expected_values[$];

  // shadow of the config registers
  logic [FLAG_CFG_W-1:0] frame_w_cfg, pixel_w_cfg;
  logic [TABLE_W-1:0]    frame_tab_cfg, pixel_tab_cfg;
  logic [COUNT_W-1:0]    count_cfg;

  // decode state
  logic               in_payload, pixel_turn;
  logic [CLASS_W-1:0] flag_acc;
  logic [LEN_W-1:0]   bit_cnt, pay_len;
  logic [VALUE_W-1:0] val_acc;
  logic [COUNT_W-1:0] done_cnt;
  int                 err_cnt;
  logic [31:0]        seen_cnt;

  task automatic clear_decode();
    in_payload = 1'b0;
    flag_acc   = '0;
    bit_cnt    = '0;
    pay_len    = '0;
    val_acc    = '0;
  endtask

  task automatic emit_value();
    decoded_t d;
    d.value    = val_acc;
    d.is_pixel = pixel_turn;
    d.last     = (done_cnt + 32'd1 == count_cfg);
    expected_values.insert(expected_values.size(), d);
    done_cnt   = done_cnt + 32'd1;
    pixel_turn = ~pixel_turn;
    clear_decode();
  endtask

  task automatic decode_bit(input logic b);
    int                 width;
    logic [TABLE_W-1:0] tab;
    logic [LEN_W-1:0]   len;
    if (done_cnt >= count_cfg) return;
    if (!in_payload) begin
      flag_acc = {flag_acc[CLASS_W-2:0], b};
      bit_cnt  = bit_cnt + 1'b1;
      width    = pixel_turn ? pixel_w_cfg : frame_w_cfg;
      if (width < 1) width = 1;
      if (width > MAX_FLAG_BITS_DEF) width = MAX_FLAG_BITS_DEF;
      if (bit_cnt >= width) begin
        tab     = pixel_turn ? pixel_tab_cfg : frame_tab_cfg;
        len     = tab[flag_acc*LEN_W +: LEN_W];
        if (len > VALUE_W) len = LEN_W'(VALUE_W);
        pay_len = len;
        bit_cnt = '0;
        val_acc = '0;
        if (len == 0) emit_value();
        else in_payload = 1'b1;
      end
    end else begin
      val_acc = {val_acc[VALUE_W-2:0], b};
      bit_cnt = bit_cnt + 1'b1;
      if (bit_cnt >= pay_len) emit_value();
    end
  endtask

  task automatic check_result();
    decoded_t d;
    seen_cnt = seen_cnt + 1;
    if (expected_values.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual value %h is_pixel %b last %b",
               $time, value, is_pixel, last);
      err_cnt++;
      return;
    end
    d = expected_values.pop_front();
    if (value !== d.value) begin
      $display("%0t: value mismatch, expected %h, actual %h", $time, d.value, value);
      err_cnt++;
    end
    if (is_pixel !== d.is_pixel) begin
      $display("%0t: is_pixel mismatch, expected %b, actual %b", $time, d.is_pixel, is_pixel);
      err_cnt++;
    end
    if (last !== d.last) begin
      $display("%0t: last mismatch, expected %b, actual %b", $time, d.last, last);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      frame_w_cfg   = 2'd1;
      pixel_w_cfg   = 2'd1;
      frame_tab_cfg = '0;
      pixel_tab_cfg = '0;
      count_cfg     = '0;
      pixel_turn    = 1'b0;
      done_cnt      = '0;
      clear_decode();
      expected_values.delete();
      err_cnt  = 0;
      seen_cnt = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_FLAG_BITS: frame_w_cfg   = cfg_data[FLAG_CFG_W-1:0];
          CFG_PIXEL_FLAG_BITS: pixel_w_cfg   = cfg_data[FLAG_CFG_W-1:0];
          CFG_FRAME_LEN_TABLE: frame_tab_cfg = cfg_data[TABLE_W-1:0];
          CFG_PIXEL_LEN_TABLE: pixel_tab_cfg = cfg_data[TABLE_W-1:0];
          CFG_VALUE_COUNT:     count_cfg     = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (bit_valid && !bit_stall) decode_bit(code_bit);
      if (res_valid && !res_stall) check_result();
    end
    errors  <= err_cnt;
    pending <= expected_values.size();
    seen    <= seen_cnt;
  end
endmodule

// ===== tb/testbench.sv =====
// Top of the decoder testbench: clock, reset, stimulus on the bit channel and
// config port, back-pressure on the result channel, watchdog and verdict.
// Depends on cvd_pkg, class_prefix_value_decoder_top and cvd_decode_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cvd_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles without any transfer
  localparam int HOLD_CYCLES = 80;    // long receiver hold-off
  localparam int DRAIN_WAIT  = 4;     // result enters the buffer the cycle after its last bit
  localparam int RAND_ITEMS  = 950;
  localparam int QUIET_FROM  = 800;   // no idling past this many bits

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic bit_valid, bit_stall, code_bit;
  logic res_valid, res_stall;
  logic [31:0] value;
  logic is_pixel, last;

  int          errors, pending;
  logic [31:0] seen;

  // stimulus-side copy of what was programmed, used only to build streams
  logic [FLAG_CFG_W-1:0] frame_w, pixel_w;
  logic [TABLE_W-1:0]    frame_tab, pixel_tab;

  bit idle_en;     // random gaps and stalls allowed
  bit hold_req;    // ask the receiver for one long hold-off
  bit counting;    // count bits toward the item budget
  int bits_sent;
  int quiet_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  class_prefix_value_decoder_top u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .bit_valid(bit_valid), .bit_stall(bit_stall), .code_bit(code_bit),
    .res_valid(res_valid), .res_stall(res_stall),
    .value(value), .is_pixel(is_pixel), .last(last)
  );

  cvd_decode_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .bit_valid(bit_valid), .bit_stall(bit_stall), .code_bit(code_bit),
    .res_valid(res_valid), .res_stall(res_stall),
    .value(value), .is_pixel(is_pixel), .last(last),
    .errors(errors), .pending(pending), .seen(seen)
  );

  // Watchdog: any cycle with a transfer on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (bit_valid && !bit_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // two-entry result buffer fills and the block pushes back on its input.
  initial begin
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  // One bit transfer, with an optional sender gap in front of it.
  task automatic send_bit(input logic b);
    if (bits_sent >= QUIET_FROM) idle_en = 1'b0;
    if (idle_en && $urandom_range(0, 9) == 0) begin
      bit_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    bit_valid <= 1'b1;
    code_bit  <= b;
    @(posedge clk);
    while (bit_stall) @(posedge clk);
    if (counting) bits_sent++;
  endtask

  // One well-formed value: class flag MSB first, then its payload.
  // pattern 0 = all ones, 1 = all zeros, other = random bits
  task automatic send_value(input bit pix, input int cls, input int pattern);
    int                 w;
    int                 len;
    logic [TABLE_W-1:0] tab;
    logic               b;
    w = pix ? pixel_w : frame_w;
    if (w < 1) w = 1;
    for (int i = w - 1; i >= 0; i--) send_bit(cls[i]);
    tab = pix ? pixel_tab : frame_tab;
    len = tab[cls*LEN_W +: LEN_W];
    if (len > 32) len = 32;
    for (int i = 0; i < len; i++) begin
      case (pattern)
        0:       b = 1'b1;
        1:       b = 1'b0;
        default: b = 1'($urandom_range(0, 1));
      endcase
      send_bit(b);
    end
  endtask

  // Stop offering, let every predicted value come out, then a few more
  // cycles so a partly decoded value can settle before a register write.
  task automatic drain();
    bit_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // cfg_we stays high across back-to-back writes; callers lower it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all five registers; narrow ones get junk in their unused bits.
  task automatic program_all(input logic [COUNT_W-1:0] count);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'({$urandom, $urandom});
    write_reg(CFG_FRAME_FLAG_BITS, {junk[CFG_DATA_W-1:FLAG_CFG_W], frame_w});
    junk = CFG_DATA_W'({$urandom, $urandom});
    write_reg(CFG_PIXEL_FLAG_BITS, {junk[CFG_DATA_W-1:FLAG_CFG_W], pixel_w});
    write_reg(CFG_FRAME_LEN_TABLE, frame_tab);
    write_reg(CFG_PIXEL_LEN_TABLE, pixel_tab);
    junk = CFG_DATA_W'({$urandom, $urandom});
    write_reg(CFG_VALUE_COUNT, {junk[CFG_DATA_W-1:COUNT_W], count});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Length table leaning toward short payloads so results come often, with
  // zero-length, full-width and saturating entries mixed in.
  function automatic logic [TABLE_W-1:0] make_table();
    logic [TABLE_W-1:0] t;
    int                 r;
    r = $urandom_range(0, 9);
    if (r == 0) return '1;
    if (r == 1) return TABLE_W'({$urandom, $urandom});
    for (int i = 0; i < NUM_CLASSES; i++) begin
      case ($urandom_range(0, 7))
        0, 1:    t[i*LEN_W +: LEN_W] = 6'd0;
        2, 3, 4: t[i*LEN_W +: LEN_W] = LEN_W'($urandom_range(1, 8));
        5:       t[i*LEN_W +: LEN_W] = 6'd32;
        6:       t[i*LEN_W +: LEN_W] = LEN_W'($urandom_range(33, 63));
        default: t[i*LEN_W +: LEN_W] = LEN_W'($urandom_range(9, 31));
      endcase
    end
    return t;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] junk;
    logic [COUNT_W-1:0]    count;
    bit                    turn;
    bit                    done_phase;
    int                    phase;
    int                    nvals;
    int                    w;
    int                    r;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    bit_valid = 1'b0;
    code_bit  = 1'b0;
    idle_en   = 1'b1;
    hold_req  = 1'b0;
    counting  = 1'b1;
    bits_sent = 0;
    frame_w   = 2'd1;
    pixel_w   = 2'd1;
    frame_tab = '0;
    pixel_tab = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // --- directed part ---
    // value count is still 0 after reset: these bits are dropped
    send_bit(1'b0);
    send_bit(1'b1);
    drain();

    // unused register indexes must be ignored
    for (int i = CFG_VALUE_COUNT + 1; i < 2**CFG_IDX_W; i++) begin
      junk = CFG_DATA_W'({$urandom, $urandom});
      write_reg(CFG_IDX_W'(i), junk);
    end

    // frame flag width 0 acts as 1; pixel flag at full width
    frame_w   = 2'd0;
    pixel_w   = 2'd3;
    frame_tab = '1;
    frame_tab[0*LEN_W +: LEN_W] = 6'd0;
    frame_tab[1*LEN_W +: LEN_W] = 6'd2;
    pixel_tab = '1;
    pixel_tab[0*LEN_W +: LEN_W] = 6'd0;
    pixel_tab[5*LEN_W +: LEN_W] = 6'd3;
    pixel_tab[7*LEN_W +: LEN_W] = 6'd1;
    program_all(32'd4);
    send_value(1'b0, 0, 0);   // zero-length frame, out on its flag bit
    send_value(1'b1, 7, 0);   // top class, one payload bit
    send_value(1'b0, 1, 0);   // two ones
    send_value(1'b1, 0, 1);   // zero-length pixel, final value
    send_bit(1'b1);           // count reached: dropped
    send_bit(1'b0);
    drain();

    // flag width changed in the middle of a flag
    frame_w = 2'd3;
    program_all(seen + 32'd2);
    send_bit(1'b0);
    drain();
    frame_w = 2'd1;
    write_one(CFG_FRAME_FLAG_BITS, {{(CFG_DATA_W-FLAG_CFG_W){1'b0}}, frame_w});
    send_bit(1'b1);           // flag now ends here, class 1
    send_bit(1'b1);
    send_bit(1'b0);
    send_value(1'b1, 5, 1);
    drain();

    // count lowered below what is already decoded: input dropped
    write_one(CFG_VALUE_COUNT, {{(CFG_DATA_W-COUNT_W){1'b0}}, 32'd3});
    send_bit(1'b1);
    send_bit(1'b1);

    // --- random part ---
    phase = 0;
    while (bits_sent < RAND_ITEMS) begin
      drain();
      idle_en   = (bits_sent < QUIET_FROM) && ($urandom_range(0, 4) != 0);
      frame_w   = FLAG_CFG_W'($urandom_range(0, 3));
      pixel_w   = FLAG_CFG_W'($urandom_range(0, 3));
      frame_tab = make_table();
      pixel_tab = make_table();
      done_phase = 1'b0;
      nvals = $urandom_range(3, 16);
      r = $urandom_range(0, 9);
      if (r == 0) begin
        count = '1;
      end else if (r == 1 && phase != 1) begin
        count = seen;         // already done: whole phase is dropped
        done_phase = 1'b1;
        nvals = 2;
      end else begin
        count = seen + $urandom_range(3, 16);
      end
      if (phase == 1) begin
        // every value zero-length: one result per flag, so the long
        // receiver hold-off backs the block up onto its input
        frame_tab = '0;
        pixel_tab = '0;
        idle_en   = 1'b0;
        nvals     = 20;
        count     = seen + 32'd20;
      end
      program_all(count);
      if (phase == 1) hold_req = 1'b1;
      counting = !done_phase;
      turn = seen[0];
      for (int i = 0; i < nvals; i++) begin
        if (bits_sent >= RAND_ITEMS) break;
        if ($urandom_range(0, 9) == 0) begin
          // stray bits knock the stream out of step with the value boundaries
          repeat ($urandom_range(1, 2)) send_bit(1'($urandom_range(0, 1)));
        end
        w = turn ? pixel_w : frame_w;
        if (w < 1) w = 1;
        send_value(turn, $urandom_range(0, (1 << w) - 1), $urandom_range(0, 5));
        turn = ~turn;
      end
      counting = 1'b1;
      phase++;
    end

    idle_en = 1'b0;
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
